>>> sv/assert_macros.svh
// Assertion macros shared by the pixel blend RTL.
// Every macro assumes a clock named clock and an active-high reset named reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define ASSERT_CLK(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

`define ASSERT_IMPLY(lbl, pre, post, msg) \
   `ASSERT_CLK(lbl, (pre) |-> (post), msg)

`endif

>>> sv/pab_pkg.sv
// Package for the pixel alpha blend block: widths, pipeline constants and item types.
// Holds the exact divide-by-channel-maximum function. Depends on nothing.
`default_nettype none

package pab_pkg;

   localparam int CHAN_BITS   = 8;
   localparam int CW          = CHAN_BITS;
   localparam int CW2         = 2 * CHAN_BITS;
   localparam int CW3         = 3 * CHAN_BITS;
   localparam int NUM_W       = CW2 + 1;
   localparam int NUM_CH      = 3;
   localparam logic [CW-1:0] CHAN_MAX = '1;

   localparam int RECIP_SHIFT = 4 * CHAN_BITS;
   localparam int RECIP_BITS  = CW3 + 1;
   localparam longint unsigned RECIP =
      (64'd1 << RECIP_SHIFT) / ((64'd1 << CHAN_BITS) - 64'd1) + 64'd1;
   localparam int PROD_W      = CW3 + RECIP_BITS;

   localparam int DIV_STEPS   = 2;
   localparam int DIV_STAGES  = CHAN_BITS / DIV_STEPS;
   localparam int PIPE_DEPTH  = 5 + DIV_STAGES;

   typedef struct packed {
      logic          req_type;
      logic [CW-1:0] base_red;
      logic [CW-1:0] base_green;
      logic [CW-1:0] base_blue;
      logic [CW-1:0] base_alpha;
      logic [CW-1:0] new_red;
      logic [CW-1:0] new_green;
      logic [CW-1:0] new_blue;
      logic [CW-1:0] new_alpha;
   } pab_req_type;

   typedef struct packed {
      logic [CW-1:0] out_red;
      logic [CW-1:0] out_green;
      logic [CW-1:0] out_blue;
      logic [CW-1:0] out_alpha;
   } pab_rsp_type;

   typedef struct packed {
      logic [NUM_W-1:0] num;
      logic [CW-1:0]    divisor;
      logic             sat;
      logic             zero;
   } pab_div_req_type;

   typedef struct packed {
      logic          mode;
      logic [CW-1:0] new_red;
      logic [CW-1:0] new_green;
      logic [CW-1:0] new_blue;
      logic [CW-1:0] new_alpha;
      logic [CW-1:0] blend_alpha;
   } pab_side_type;

   // Exact floor(x / CHAN_MAX) for any x up to CHAN_MAX cubed.
   function automatic logic [CW2-1:0] div_max(input logic [CW3-1:0] x);
      logic [PROD_W-1:0] prod;
      prod = PROD_W'(x) * PROD_W'(RECIP);
      return prod[RECIP_SHIFT +: CW2];
   endfunction

endpackage

`default_nettype wire

>>> sv/pab_premul.sv
// Front pipeline of the pixel blend: output alpha, weighted base term and numerators.
// Four register stages. Depends on pab_pkg.
`default_nettype none
`include "assert_macros.svh"

module pab_premul
   import pab_pkg::*;
(
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            in_valid,
   input  wire pab_req_type     in_data,
   output logic                 out_valid,
   output pab_div_req_type      out_req [NUM_CH],
   output pab_side_type         out_side
);

   logic [CW-1:0]  cn [NUM_CH];
   logic [CW-1:0]  cb [NUM_CH];
   pab_side_type   side_in;
   logic [CW-1:0]  inv_an;

   logic           a_vld_ff;
   logic [CW2-1:0] a_p_ff;
   logic [CW2-1:0] a_cnan_ff [NUM_CH];
   logic [CW-1:0]  a_cb_ff [NUM_CH];
   pab_side_type   a_side_ff;

   logic [CW2-1:0] alpha_q;
   logic [CW-1:0]  alpha_in;
   pab_side_type   side_b_in;
   logic           b_vld_ff;
   logic [CW3-1:0] b_cbp_ff [NUM_CH];
   logic [CW2-1:0] b_cnan_ff [NUM_CH];
   pab_side_type   b_side_ff;

   logic           c_vld_ff;
   logic [CW2-1:0] c_t_ff [NUM_CH];
   logic [CW2-1:0] c_cnan_ff [NUM_CH];
   pab_side_type   c_side_ff;

   pab_div_req_type d_req_in [NUM_CH];
   logic            d_vld_ff;
   pab_div_req_type d_req_ff [NUM_CH];
   pab_side_type    d_side_ff;

   always_comb begin
      cn[0] = in_data.new_red;
      cn[1] = in_data.new_green;
      cn[2] = in_data.new_blue;
      cb[0] = in_data.base_red;
      cb[1] = in_data.base_green;
      cb[2] = in_data.base_blue;
      inv_an = CHAN_MAX - in_data.new_alpha;
      side_in.mode        = in_data.req_type;
      side_in.new_red     = in_data.new_red;
      side_in.new_green   = in_data.new_green;
      side_in.new_blue    = in_data.new_blue;
      side_in.new_alpha   = in_data.new_alpha;
      side_in.blend_alpha = '0;
   end

   always_comb begin
      alpha_q  = div_max(CW3'(a_p_ff));
      alpha_in = a_side_ff.new_alpha + alpha_q[CW-1:0];
      side_b_in = a_side_ff;
      side_b_in.blend_alpha = alpha_in;
   end

   always_comb begin
      logic [NUM_W-1:0] num;
      for (int i = 0; i < NUM_CH; i++) begin
         num = NUM_W'(c_cnan_ff[i]) + NUM_W'(c_t_ff[i]);
         d_req_in[i].num     = num;
         d_req_in[i].divisor = c_side_ff.blend_alpha;
         d_req_in[i].sat     = (num[NUM_W-1:CW] >= (CW+1)'(c_side_ff.blend_alpha));
         d_req_in[i].zero    = (c_side_ff.blend_alpha == '0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff <= 1'b0;
         b_vld_ff <= 1'b0;
         c_vld_ff <= 1'b0;
         d_vld_ff <= 1'b0;
      end else begin
         a_vld_ff <= in_valid;
         b_vld_ff <= a_vld_ff;
         c_vld_ff <= b_vld_ff;
         d_vld_ff <= c_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      a_p_ff    <= CW2'(inv_an) * CW2'(in_data.base_alpha);
      a_side_ff <= side_in;
      b_side_ff <= side_b_in;
      c_side_ff <= b_side_ff;
      d_side_ff <= c_side_ff;
      for (int i = 0; i < NUM_CH; i++) begin
         a_cnan_ff[i] <= CW2'(cn[i]) * CW2'(in_data.new_alpha);
         a_cb_ff[i]   <= cb[i];
         b_cbp_ff[i]  <= CW3'(a_cb_ff[i]) * CW3'(a_p_ff);
         b_cnan_ff[i] <= a_cnan_ff[i];
         c_t_ff[i]    <= div_max(b_cbp_ff[i]);
         c_cnan_ff[i] <= b_cnan_ff[i];
         d_req_ff[i]  <= d_req_in[i];
      end
   end

   assign out_valid = d_vld_ff;
   assign out_req   = d_req_ff;
   assign out_side  = d_side_ff;

   `ASSERT_IMPLY(a_alpha_floor, b_vld_ff, b_side_ff.blend_alpha >= b_side_ff.new_alpha, "blended alpha below new alpha")

endmodule

`default_nettype wire

>>> sv/pab_div.sv
// Pipelined restoring divider for one color lane, two quotient bits per stage.
// Applies the zero-alpha and saturation overrides. Depends on pab_pkg.
`default_nettype none
`include "assert_macros.svh"

module pab_div
   import pab_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             in_valid,
   input  wire pab_div_req_type  in_req,
   output logic                  out_valid,
   output logic [CW-1:0]         out_value
);

   localparam int LAST = DIV_STAGES - 1;

   logic          vld_ff  [DIV_STAGES];
   logic [CW:0]   rem_ff  [DIV_STAGES];
   logic [CW-1:0] work_ff [DIV_STAGES];
   logic [CW-1:0] dvs_ff  [DIV_STAGES];
   logic          sat_ff  [DIV_STAGES];
   logic          zero_ff [DIV_STAGES];
   logic [CW:0]   rem_in  [DIV_STAGES];
   logic [CW-1:0] work_in [DIV_STAGES];

   for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
      logic          vld_src;
      logic [CW:0]   rem_src;
      logic [CW-1:0] work_src;
      logic [CW-1:0] dvs_src;
      logic          sat_src;
      logic          zero_src;

      if (s == 0) begin : g_first
         assign vld_src  = in_valid;
         assign rem_src  = in_req.num[NUM_W-1:CW];
         assign work_src = in_req.num[CW-1:0];
         assign dvs_src  = in_req.divisor;
         assign sat_src  = in_req.sat;
         assign zero_src = in_req.zero;
      end else begin : g_next
         assign vld_src  = vld_ff[s-1];
         assign rem_src  = rem_ff[s-1];
         assign work_src = work_ff[s-1];
         assign dvs_src  = dvs_ff[s-1];
         assign sat_src  = sat_ff[s-1];
         assign zero_src = zero_ff[s-1];
      end

      always_comb begin
         logic [CW:0]   trial;
         logic [CW:0]   rem_t;
         logic [CW-1:0] work_t;
         rem_t  = rem_src;
         work_t = work_src;
         for (int j = 0; j < DIV_STEPS; j++) begin
            trial = {rem_t[CW-1:0], work_t[CW-1]};
            if (trial >= {1'b0, dvs_src}) begin
               rem_t  = trial - {1'b0, dvs_src};
               work_t = {work_t[CW-2:0], 1'b1};
            end else begin
               rem_t  = trial;
               work_t = {work_t[CW-2:0], 1'b0};
            end
         end
         rem_in[s]  = rem_t;
         work_in[s] = work_t;
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[s] <= 1'b0;
         end else begin
            vld_ff[s] <= vld_src;
         end
      end

      always_ff @(posedge clock) begin
         rem_ff[s]  <= rem_in[s];
         work_ff[s] <= work_in[s];
         dvs_ff[s]  <= dvs_src;
         sat_ff[s]  <= sat_src;
         zero_ff[s] <= zero_src;
      end
   end

   always_comb begin
      if (zero_ff[LAST]) begin
         out_value = '0;
      end else if (sat_ff[LAST]) begin
         out_value = CHAN_MAX;
      end else begin
         out_value = work_ff[LAST];
      end
   end

   assign out_valid = vld_ff[LAST];

   `ASSERT_IMPLY(a_rem_bound, vld_ff[LAST] && !sat_ff[LAST] && !zero_ff[LAST], rem_ff[LAST] < {1'b0, dvs_ff[LAST]}, "divider remainder not below divisor")

endmodule

`default_nettype wire

>>> sv/pixel_alpha_blend.sv
// Each accepted item strobes its result on rsp_valid, in the order the items were accepted.
// Throughput: one item per cycle; busy is low whenever reset is low.
// The depth is set by four front stages (multiply and divide-by-maximum), four divider
// stages at two quotient bits each, and the output register.
// Synchronous reset clears all valid bits; no result is lost or repeated afterwards.
`default_nettype none
`include "assert_macros.svh"

module pixel_alpha_blend
   import pab_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          start,
   output logic               busy,
   input  wire pab_req_type   req_data,
   output logic               rsp_valid,
   output pab_rsp_type        rsp_data
);

   logic            pre_valid;
   pab_div_req_type pre_req [NUM_CH];
   pab_side_type    pre_side;

   logic            lane_valid [NUM_CH];
   logic [CW-1:0]   lane_value [NUM_CH];

   pab_side_type    side_ff [DIV_STAGES];
   logic            rsp_valid_in;
   pab_rsp_type     rsp_data_in;
   logic            rsp_valid_ff;
   pab_rsp_type     rsp_data_ff;

   assign busy = reset;

   pab_premul u_premul (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (start && !busy),
      .in_data   (req_data),
      .out_valid (pre_valid),
      .out_req   (pre_req),
      .out_side  (pre_side)
   );

   for (genvar i = 0; i < NUM_CH; i++) begin : g_lane
      pab_div u_div (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (pre_valid),
         .in_req    (pre_req[i]),
         .out_valid (lane_valid[i]),
         .out_value (lane_value[i])
      );
   end

   always_ff @(posedge clock) begin
      side_ff[0] <= pre_side;
      for (int s = 1; s < DIV_STAGES; s++) begin
         side_ff[s] <= side_ff[s-1];
      end
   end

   always_comb begin
      rsp_valid_in = lane_valid[0] && lane_valid[1] && lane_valid[2];
      if (side_ff[DIV_STAGES-1].mode) begin
         rsp_data_in.out_red   = lane_value[0];
         rsp_data_in.out_green = lane_value[1];
         rsp_data_in.out_blue  = lane_value[2];
         rsp_data_in.out_alpha = side_ff[DIV_STAGES-1].blend_alpha;
      end else begin
         rsp_data_in.out_red   = side_ff[DIV_STAGES-1].new_red;
         rsp_data_in.out_green = side_ff[DIV_STAGES-1].new_green;
         rsp_data_in.out_blue  = side_ff[DIV_STAGES-1].new_blue;
         rsp_data_in.out_alpha = side_ff[DIV_STAGES-1].new_alpha;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `ASSERT_CLK(a_item_returns, (start && !busy) |-> ##PIPE_DEPTH rsp_valid, "accepted item gave no result")
   `ASSERT_IMPLY(a_no_spurious, rsp_valid, $past(start && !busy, PIPE_DEPTH), "result without accepted item")

endmodule

`default_nettype wire
